// ----- rtl/cgnp_pkg.sv -----
// Shared constants and controller/datapath interface types for the near-pair finder.
`timescale 1ns / 1ps

package cgnp_pkg;

   localparam int POINT_CAPACITY     = 4096;
   localparam int NUM_GROUPS         = 8;
   localparam int MAX_HITS_PER_POINT = 16;

   localparam int ADDR_W   = $clog2(POINT_CAPACITY);
   localparam int COUNT_W  = $clog2(POINT_CAPACITY + 1);
   localparam int HIT_W    = $clog2(MAX_HITS_PER_POINT + 1);
   localparam int GROUP_W  = 3;
   localparam int COORD_W  = 32;
   localparam int DIST_W   = 16;
   localparam int SQ_W     = 2 * DIST_W;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_CLOSE_DISTANCE = 1'b0;

   localparam logic [DIST_W-1:0] CLOSE_DISTANCE_RESET = DIST_W'(1678);

   typedef struct packed {
      logic             valid;
      logic             is_match;
      logic [GROUP_W-1:0] group_low;
      logic [GROUP_W-1:0] group_high;
      logic [COORD_W-1:0] mid_x;
      logic [COORD_W-1:0] mid_y;
      logic             hits_dropped;
      logic             store_full;
      logic             last;
   } result_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic close;
   } dp_cmd_type;

   typedef struct packed {
      logic skip;
      logic scan_done;
      logic pipe_busy;
   } dp_stat_type;

endpackage

// ----- rtl/cgnp_ctrl.sv -----
// Controller state machine: sequences load, store scan, pipeline drain and closing transaction.
`timescale 1ns / 1ps

module cgnp_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  cgnp_pkg::dp_stat_type stat,
   output cgnp_pkg::dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_CLOSE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.load  = 1'b0;
      cmd.issue = 1'b0;
      cmd.close = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.skip) begin
               state_in = ST_CLOSE;
            end else if (stat.scan_done) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) state_in = ST_CLOSE;
         end
         ST_CLOSE: begin
            cmd.close = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- rtl/cgnp_datapath.sv -----
// Datapath: point store, distance pipeline, hit counting and result register.
`timescale 1ns / 1ps

module cgnp_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cgnp_pkg::dp_cmd_type                  cmd,
   output cgnp_pkg::dp_stat_type                 stat,
   input  logic [cgnp_pkg::DIST_W-1:0]           close_distance,
   input  logic                                  operation,
   input  logic [cgnp_pkg::GROUP_W-1:0]          group_id,
   input  logic signed [cgnp_pkg::COORD_W-1:0]   x_pos,
   input  logic signed [cgnp_pkg::COORD_W-1:0]   y_pos,
   output cgnp_pkg::result_type                  result
);

   localparam int AW = cgnp_pkg::ADDR_W;
   localparam int CW = cgnp_pkg::COUNT_W;
   localparam int GW = cgnp_pkg::GROUP_W;
   localparam int XW = cgnp_pkg::COORD_W;
   localparam int DW = cgnp_pkg::DIST_W;
   localparam int SW = cgnp_pkg::SQ_W;
   localparam int HW = cgnp_pkg::HIT_W;
   localparam logic [CW-1:0] CAPACITY = CW'(cgnp_pkg::POINT_CAPACITY);
   localparam logic [HW-1:0] HIT_LIMIT = HW'(cgnp_pkg::MAX_HITS_PER_POINT);
   localparam logic [GW:0]   GROUP_LIMIT = (GW + 1)'(cgnp_pkg::NUM_GROUPS);

   typedef struct packed {
      logic [GW-1:0] grp;
      logic [XW-1:0] x;
      logic [XW-1:0] y;
   } entry_type;

   entry_type mem [cgnp_pkg::POINT_CAPACITY];

   // current transaction
   logic                 op_ff;
   logic [GW-1:0]        grp_ff;
   logic signed [XW-1:0] x_ff, y_ff;
   logic [DW-1:0]        r_ff;
   logic [SW-1:0]        r2_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff;
   logic [HW-1:0]        hits_ff, hits_in;
   logic                 dropped_ff, dropped_in;

   // pipeline
   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   entry_type            rd_ff;
   logic signed [XW:0]   dx2_ff, dy2_ff, sx2_ff, sy2_ff;
   logic [GW-1:0]        g2_ff;
   logic                 near3_ff;
   logic [DW-1:0]        dx3_ff, dy3_ff;
   logic [XW-1:0]        mx3_ff, my3_ff, mx4_ff, my4_ff;
   logic [GW-1:0]        lo3_ff, hi3_ff, lo4_ff, hi4_ff;
   logic                 near4_ff;
   logic [SW-1:0]        sqx4_ff, sqy4_ff;

   cgnp_pkg::result_type result_ff, result_in;

   logic                 grp_bad;
   logic                 store_ok;
   logic [XW:0]          ax, ay;
   logic [SW:0]          d2;
   logic                 hit;

   assign grp_bad  = ({1'b0, grp_ff} >= GROUP_LIMIT);
   assign store_ok = (count_ff < CAPACITY);

   assign stat.skip      = (op_ff == cgnp_pkg::OP_CLEAR) || grp_bad;
   assign stat.scan_done = (idx_ff == count_ff);
   assign stat.pipe_busy = v1_ff | v2_ff | v3_ff | v4_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= operation;
         grp_ff <= group_id;
         x_ff   <= x_pos;
         y_ff   <= y_pos;
         r_ff   <= close_distance;
         r2_ff  <= close_distance * close_distance;
      end
   end

   // store
   always_ff @(posedge clock) begin
      if (cmd.issue) rd_ff <= mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.close && op_ff == cgnp_pkg::OP_INSERT && !grp_bad && store_ok)
         mem[count_ff[AW-1:0]] <= '{grp: grp_ff, x: x_ff, y: y_ff};
   end

   // stage 2: differences and sums
   always_ff @(posedge clock) begin
      dx2_ff <= {x_ff[XW-1], x_ff} - {rd_ff.x[XW-1], rd_ff.x};
      dy2_ff <= {y_ff[XW-1], y_ff} - {rd_ff.y[XW-1], rd_ff.y};
      sx2_ff <= {x_ff[XW-1], x_ff} + {rd_ff.x[XW-1], rd_ff.x};
      sy2_ff <= {y_ff[XW-1], y_ff} + {rd_ff.y[XW-1], rd_ff.y};
      g2_ff  <= rd_ff.grp;
   end

   // stage 3: magnitudes and box test
   assign ax = dx2_ff[XW] ? (XW + 1)'(-dx2_ff) : dx2_ff;
   assign ay = dy2_ff[XW] ? (XW + 1)'(-dy2_ff) : dy2_ff;

   always_ff @(posedge clock) begin
      near3_ff <= (g2_ff != grp_ff) && (ax < {{(XW + 1 - DW){1'b0}}, r_ff})
                  && (ay < {{(XW + 1 - DW){1'b0}}, r_ff});
      dx3_ff   <= ax[DW-1:0];
      dy3_ff   <= ay[DW-1:0];
      mx3_ff   <= sx2_ff[XW:1];
      my3_ff   <= sy2_ff[XW:1];
      lo3_ff   <= (g2_ff < grp_ff) ? g2_ff : grp_ff;
      hi3_ff   <= (g2_ff < grp_ff) ? grp_ff : g2_ff;
   end

   // stage 4: squares
   always_ff @(posedge clock) begin
      sqx4_ff  <= dx3_ff * dx3_ff;
      sqy4_ff  <= dy3_ff * dy3_ff;
      near4_ff <= near3_ff;
      mx4_ff   <= mx3_ff;
      my4_ff   <= my3_ff;
      lo4_ff   <= lo3_ff;
      hi4_ff   <= hi3_ff;
   end

   // stage 5: radius test and result
   assign d2  = {1'b0, sqx4_ff} + {1'b0, sqy4_ff};
   assign hit = v4_ff && near4_ff && (d2 < {1'b0, r2_ff});

   always_comb begin
      count_in   = count_ff;
      hits_in    = hits_ff;
      dropped_in = dropped_ff;
      result_in  = '0;
      if (cmd.load) begin
         hits_in    = '0;
         dropped_in = 1'b0;
      end
      if (hit) begin
         if (hits_ff < HIT_LIMIT) begin
            hits_in              = hits_ff + HW'(1);
            result_in.valid      = 1'b1;
            result_in.is_match   = 1'b1;
            result_in.group_low  = lo4_ff;
            result_in.group_high = hi4_ff;
            result_in.mid_x      = mx4_ff;
            result_in.mid_y      = my4_ff;
         end else begin
            dropped_in = 1'b1;
         end
      end
      if (cmd.close) begin
         result_in.valid = 1'b1;
         result_in.last  = 1'b1;
         if (op_ff == cgnp_pkg::OP_CLEAR) begin
            count_in = '0;
         end else if (!grp_bad) begin
            result_in.hits_dropped = dropped_ff;
            if (store_ok) count_in = count_ff + CW'(1);
            else          result_in.store_full = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         idx_ff     <= '0;
         hits_ff    <= '0;
         dropped_ff <= 1'b0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         v4_ff      <= 1'b0;
         result_ff  <= '0;
      end else begin
         count_ff   <= count_in;
         hits_ff    <= hits_in;
         dropped_ff <= dropped_in;
         if (cmd.load)       idx_ff <= '0;
         else if (cmd.issue) idx_ff <= idx_ff + CW'(1);
         v1_ff      <= cmd.issue;
         v2_ff      <= v1_ff;
         v3_ff      <= v2_ff;
         v4_ff      <= v3_ff;
         result_ff  <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// ----- rtl/cross_group_near_pair_finder.sv -----
// Top level: near-pair finder with APB register, controller and datapath.
`timescale 1ns / 1ps
//
// Usage: drive req_* and pulse start while busy is low; the transaction is taken at that
// edge and busy rises. req_operation insert compares the point with every stored point
// of another group, one stored point per cycle from the store's single read port, then
// stores it. Each close pair yields one rsp_valid strobe with rsp_is_match set (at most
// MAX_HITS_PER_POINT); a closing strobe with rsp_last set always ends the run and
// carries hits_dropped and store_full. Clear, or a group out of range, gives only the
// closing strobe.
// An insert scans the N stored points, drains a five-stage distance pipeline and ends
// in a closing state; busy drops as the closing strobe appears, so the next
// transaction may start at the edge that takes it. A new transaction is not taken
// before the closing strobe of the current one.
// Results appear for exactly one cycle; the receiver cannot stall them.
// Reset empties the store and sets close_distance to 1678; store contents are not
// cleared. The user must write close_distance through the APB port only while idle;
// the block itself does not enforce it.
module cross_group_near_pair_finder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_operation,
   input  logic [cgnp_pkg::GROUP_W-1:0]         req_group_id,
   input  logic signed [cgnp_pkg::COORD_W-1:0]  req_x_pos,
   input  logic signed [cgnp_pkg::COORD_W-1:0]  req_y_pos,
   output logic                                 rsp_valid,
   output logic                                 rsp_is_match,
   output logic [cgnp_pkg::GROUP_W-1:0]         rsp_group_low,
   output logic [cgnp_pkg::GROUP_W-1:0]         rsp_group_high,
   output logic signed [cgnp_pkg::COORD_W-1:0]  rsp_mid_x,
   output logic signed [cgnp_pkg::COORD_W-1:0]  rsp_mid_y,
   output logic                                 rsp_hits_dropped,
   output logic                                 rsp_store_full,
   output logic                                 rsp_last,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [cgnp_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [cgnp_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [cgnp_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   localparam int DW = cgnp_pkg::DIST_W;

   logic [DW-1:0]         close_distance_ff;
   logic                  csr_sel_dist;
   cgnp_pkg::dp_cmd_type  cmd;
   cgnp_pkg::dp_stat_type stat;
   cgnp_pkg::result_type  result;

   assign pready       = 1'b1;
   assign csr_sel_dist = (paddr[cgnp_pkg::CSR_ADDR_W-1] == cgnp_pkg::CSR_IDX_CLOSE_DISTANCE);

   always_ff @(posedge clock) begin
      if (reset) begin
         close_distance_ff <= cgnp_pkg::CLOSE_DISTANCE_RESET;
      end else if (psel && penable && pwrite && pready && csr_sel_dist) begin
         close_distance_ff <= pwdata[DW-1:0];
      end
   end

   assign prdata = csr_sel_dist ? {{(cgnp_pkg::CSR_DATA_W - DW){1'b0}}, close_distance_ff}
                                : '0;

   cgnp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   cgnp_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .close_distance (close_distance_ff),
      .operation      (req_operation),
      .group_id       (req_group_id),
      .x_pos          (req_x_pos),
      .y_pos          (req_y_pos),
      .result         (result)
   );

   assign rsp_valid        = result.valid;
   assign rsp_is_match     = result.is_match;
   assign rsp_group_low    = result.group_low;
   assign rsp_group_high   = result.group_high;
   assign rsp_mid_x        = result.mid_x;
   assign rsp_mid_y        = result.mid_y;
   assign rsp_hits_dropped = result.hits_dropped;
   assign rsp_store_full   = result.store_full;
   assign rsp_last         = result.last;

`ifndef ASSERT_OFF
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted transaction");

   a_match_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_match |-> busy && !rsp_last)
      else $error("match result outside a running transaction");

   a_close_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("result strobe right after the closing transaction");

   a_close_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy && !rsp_is_match)
      else $error("closing result while still busy");
`endif

endmodule

// ----- sim/cross_group_near_pair_finder_test.sv -----
// Self-checking testbench for the near-pair finder: directed table and random phases.
`timescale 1ns / 1ps

module cross_group_near_pair_finder_test;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int NUM_PHASES     = 5;
   localparam int NUM_CLUSTERS   = 4;
   localparam logic [cgnp_pkg::CSR_ADDR_W-1:0] CLOSE_DISTANCE_ADDR =
      cgnp_pkg::CSR_ADDR_W'(4 * cgnp_pkg::CSR_IDX_CLOSE_DISTANCE);

   localparam int PHASE_RADIUS [NUM_PHASES] = '{0, 65535, 1678, 5000, 300};
   localparam int PHASE_IDLE   [NUM_PHASES] = '{0, 84, 34, 0, 84};
   localparam int PHASE_ITEMS  [NUM_PHASES] = '{15, 25, 25, 25, 25};

   typedef struct packed {
      logic                         operation;
      logic [cgnp_pkg::GROUP_W-1:0] group_id;
      logic [cgnp_pkg::COORD_W-1:0] x_pos;
      logic [cgnp_pkg::COORD_W-1:0] y_pos;
   } point_cmd_type;

   typedef struct packed {
      logic                         is_match;
      logic [cgnp_pkg::GROUP_W-1:0] group_low;
      logic [cgnp_pkg::GROUP_W-1:0] group_high;
      logic [cgnp_pkg::COORD_W-1:0] mid_x;
      logic [cgnp_pkg::COORD_W-1:0] mid_y;
      logic                         hits_dropped;
      logic                         store_full;
      logic                         last;
   } near_hit_type;

   typedef struct packed {
      logic                         operation;
      logic [cgnp_pkg::GROUP_W-1:0] group_id;
      logic [cgnp_pkg::COORD_W-1:0] x_pos;
      logic [cgnp_pkg::COORD_W-1:0] y_pos;
      logic                         closing_only;
   } stim_row_type;

   localparam near_hit_type CLOSING_CLEAN =
      near_hit_type'{1'b0, 3'd0, 3'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1};

   // closing_only rows expect just a clean closing transaction
   localparam stim_row_type DIRECTED_ROWS [25] = '{
      '{cgnp_pkg::OP_INSERT, 3'd0, 32'd0, 32'd0, 1'b1},
      '{cgnp_pkg::OP_CLEAR,  3'd0, 32'd0, 32'd0, 1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd1, 32'd0,  32'd0,    1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd1, 32'd3,  -32'sd2,  1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd1, 32'd6,  -32'sd4,  1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd1, 32'd9,  -32'sd6,  1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd1, 32'd12, -32'sd8,  1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd1, 32'd15, -32'sd10, 1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd1, 32'd18, -32'sd12, 1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd1, 32'd21, -32'sd14, 1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd1, 32'd24, -32'sd16, 1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd1, 32'd27, -32'sd18, 1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd1, 32'd30, -32'sd20, 1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd1, 32'd33, -32'sd22, 1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd1, 32'd36, -32'sd24, 1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd1, 32'd39, -32'sd26, 1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd1, 32'd42, -32'sd28, 1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd1, 32'd45, -32'sd30, 1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd1, 32'd48, -32'sd32, 1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd2, 32'd1,  -32'sd1,  1'b0},
      '{cgnp_pkg::OP_INSERT, 3'd7, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd0, 32'h7FFF_FC17, 32'h8000_04B0, 1'b0},
      '{cgnp_pkg::OP_INSERT, 3'd7, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1},
      '{cgnp_pkg::OP_INSERT, 3'd5, 32'h8000_068D, 32'h7FFF_FFFF, 1'b0},
      '{cgnp_pkg::OP_INSERT, 3'd4, 32'h8000_0000, 32'h7FFF_F971, 1'b0}
   };

   logic                                 clock;
   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic                                 req_operation;
   logic [cgnp_pkg::GROUP_W-1:0]         req_group_id;
   logic signed [cgnp_pkg::COORD_W-1:0]  req_x_pos;
   logic signed [cgnp_pkg::COORD_W-1:0]  req_y_pos;
   logic                                 rsp_valid;
   logic                                 rsp_is_match;
   logic [cgnp_pkg::GROUP_W-1:0]         rsp_group_low;
   logic [cgnp_pkg::GROUP_W-1:0]         rsp_group_high;
   logic signed [cgnp_pkg::COORD_W-1:0]  rsp_mid_x;
   logic signed [cgnp_pkg::COORD_W-1:0]  rsp_mid_y;
   logic                                 rsp_hits_dropped;
   logic                                 rsp_store_full;
   logic                                 rsp_last;
   logic                                 psel;
   logic                                 penable;
   logic                                 pwrite;
   logic [cgnp_pkg::CSR_ADDR_W-1:0]      paddr;
   logic [cgnp_pkg::CSR_DATA_W-1:0]      pwdata;
   logic [cgnp_pkg::CSR_DATA_W-1:0]      prdata;
   logic                                 pready;

   // predictor state
   logic signed [cgnp_pkg::COORD_W-1:0]  stored_x [cgnp_pkg::POINT_CAPACITY];
   logic signed [cgnp_pkg::COORD_W-1:0]  stored_y [cgnp_pkg::POINT_CAPACITY];
   logic [cgnp_pkg::GROUP_W-1:0]         stored_group [cgnp_pkg::POINT_CAPACITY];
   int                                   stored_count = 0;
   logic [cgnp_pkg::DIST_W-1:0]          close_radius = cgnp_pkg::CLOSE_DISTANCE_RESET;

   near_hit_type                         pending_hits [$];
   logic [cgnp_pkg::COORD_W-1:0]         cluster_x [NUM_CLUSTERS];
   logic [cgnp_pkg::COORD_W-1:0]         cluster_y [NUM_CLUSTERS];
   int                                   send_idle_pct = 0;
   int                                   error_count = 0;
   int                                   idle_cycles_ff = 0;

   cross_group_near_pair_finder u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_group_id     (req_group_id),
      .req_x_pos        (req_x_pos),
      .req_y_pos        (req_y_pos),
      .rsp_valid        (rsp_valid),
      .rsp_is_match     (rsp_is_match),
      .rsp_group_low    (rsp_group_low),
      .rsp_group_high   (rsp_group_high),
      .rsp_mid_x        (rsp_mid_x),
      .rsp_mid_y        (rsp_mid_y),
      .rsp_hits_dropped (rsp_hits_dropped),
      .rsp_store_full   (rsp_store_full),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic string describe(input near_hit_type h);
      return $sformatf("match=%0b groups=%0d/%0d mid=(%h,%h) dropped=%0b full=%0b last=%0b",
                       h.is_match, h.group_low, h.group_high, h.mid_x, h.mid_y,
                       h.hits_dropped, h.store_full, h.last);
   endfunction

   function automatic void predict_point(input point_cmd_type cmd,
                                         output near_hit_type hits [$]);
      near_hit_type h;
      longint       dx;
      longint       dy;
      longint       lim;
      longint       half;
      int           n;
      logic         dropped;
      logic         full;
      hits = {};
      n = 0;
      dropped = 1'b0;
      full = 1'b0;
      lim = longint'(close_radius);
      if (cmd.operation == cgnp_pkg::OP_CLEAR) begin
         stored_count = 0;
         hits = {hits, CLOSING_CLEAN};
         return;
      end
      for (int i = 0; i < stored_count; i++) begin
         if (stored_group[i] == cmd.group_id)
            continue;
         dx = longint'($signed(cmd.x_pos)) - longint'(stored_x[i]);
         dy = longint'($signed(cmd.y_pos)) - longint'(stored_y[i]);
         if (dx < 0)
            dx = -dx;
         if (dy < 0)
            dy = -dy;
         if (dx >= lim || dy >= lim)
            continue;
         if (dx * dx + dy * dy >= lim * lim)
            continue;
         if (n < cgnp_pkg::MAX_HITS_PER_POINT) begin
            h = CLOSING_CLEAN;
            h.is_match = 1'b1;
            h.last = 1'b0;
            h.group_low = (stored_group[i] < cmd.group_id) ? stored_group[i] : cmd.group_id;
            h.group_high = (stored_group[i] < cmd.group_id) ? cmd.group_id : stored_group[i];
            half = (longint'($signed(cmd.x_pos)) + longint'(stored_x[i])) >>> 1;
            h.mid_x = half[cgnp_pkg::COORD_W-1:0];
            half = (longint'($signed(cmd.y_pos)) + longint'(stored_y[i])) >>> 1;
            h.mid_y = half[cgnp_pkg::COORD_W-1:0];
            hits = {hits, h};
            n++;
         end else begin
            dropped = 1'b1;
         end
      end
      if (stored_count < cgnp_pkg::POINT_CAPACITY) begin
         stored_x[stored_count] = cmd.x_pos;
         stored_y[stored_count] = cmd.y_pos;
         stored_group[stored_count] = cmd.group_id;
         stored_count++;
      end else begin
         full = 1'b1;
      end
      h = CLOSING_CLEAN;
      h.hits_dropped = dropped;
      h.store_full = full;
      hits = {hits, h};
   endfunction

   function automatic point_cmd_type random_point(input int span);
      point_cmd_type c;
      int            pick;
      int            k;
      pick = $urandom_range(99);
      k = $urandom_range(NUM_CLUSTERS - 1);
      c.operation = (pick < 4) ? cgnp_pkg::OP_CLEAR : cgnp_pkg::OP_INSERT;
      c.group_id = cgnp_pkg::GROUP_W'($urandom_range(cgnp_pkg::NUM_GROUPS - 1));
      if (pick < 14) begin
         c.x_pos = $urandom;
         c.y_pos = $urandom;
      end else begin
         c.x_pos = cluster_x[k] + cgnp_pkg::COORD_W'($urandom_range(2 * span) - span);
         c.y_pos = cluster_y[k] + cgnp_pkg::COORD_W'($urandom_range(2 * span) - span);
      end
      return c;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_command(input point_cmd_type cmd, input logic closing_only);
      near_hit_type hits [$];
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_operation <= cmd.operation;
      req_group_id <= cmd.group_id;
      req_x_pos <= cmd.x_pos;
      req_y_pos <= cmd.y_pos;
      do @(posedge clock); while (busy);
      predict_point(cmd, hits);
      if (closing_only)
         pending_hits = {pending_hits, CLOSING_CLEAN};
      else
         pending_hits = {pending_hits, hits};
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      do @(negedge clock); while (pending_hits.size() != 0 || busy);
   endtask

   task automatic csr_write(input logic [cgnp_pkg::DIST_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CLOSE_DISTANCE_ADDR;
      pwdata <= cgnp_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      close_radius = value;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic csr_check(input logic [cgnp_pkg::DIST_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= CLOSE_DISTANCE_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== cgnp_pkg::CSR_DATA_W'(value)) begin
         error_count++;
         $display("%0t: close_distance read mismatch: expected %h, actual %h",
                  $time, cgnp_pkg::CSR_DATA_W'(value), prdata);
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   always @(posedge clock) begin
      near_hit_type seen;
      near_hit_type want;
      if (!reset && rsp_valid) begin
         seen = '{rsp_is_match, rsp_group_low, rsp_group_high, rsp_mid_x, rsp_mid_y,
                  rsp_hits_dropped, rsp_store_full, rsp_last};
         if (pending_hits.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transaction: expected none, actual %s",
                     $time, describe(seen));
         end else begin
            want = pending_hits.pop_front();
            if (seen.is_match !== want.is_match || seen.group_low !== want.group_low ||
                seen.group_high !== want.group_high || seen.mid_x !== want.mid_x ||
                seen.mid_y !== want.mid_y || seen.hits_dropped !== want.hits_dropped ||
                seen.store_full !== want.store_full || seen.last !== want.last) begin
               error_count++;
               $display("%0t: result mismatch: expected %s, actual %s",
                        $time, describe(want), describe(seen));
            end
         end
      end
   end

   // counts cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles_ff <= 0;
      end else if (idle_cycles_ff == WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired", $time);
         $display("cross_group_near_pair_finder_test: done, errors");
         $finish;
      end else begin
         idle_cycles_ff <= idle_cycles_ff + 1;
      end
   end

   initial begin
      int span;
      reset = 1'b1;
      start = 1'b0;
      req_operation = cgnp_pkg::OP_INSERT;
      req_group_id = '0;
      req_x_pos = '0;
      req_y_pos = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      csr_check(cgnp_pkg::CLOSE_DISTANCE_RESET);

      foreach (DIRECTED_ROWS[i])
         send_command(point_cmd_type'{DIRECTED_ROWS[i].operation, DIRECTED_ROWS[i].group_id,
                                      DIRECTED_ROWS[i].x_pos, DIRECTED_ROWS[i].y_pos},
                      DIRECTED_ROWS[i].closing_only);

      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_for_results();
         csr_write(cgnp_pkg::DIST_W'(PHASE_RADIUS[p]));
         csr_check(cgnp_pkg::DIST_W'(PHASE_RADIUS[p]));
         send_idle_pct = PHASE_IDLE[p];
         span = PHASE_RADIUS[p] * 2 + 8;
         foreach (cluster_x[k]) begin
            cluster_x[k] = $urandom;
            cluster_y[k] = $urandom;
         end
         repeat (PHASE_ITEMS[p]) begin
            if ($urandom_range(19) == 0)
               wait_for_results();
            send_command(random_point(span), 1'b0);
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("cross_group_near_pair_finder_test: done, clean");
      else
         $display("cross_group_near_pair_finder_test: done, errors");
      $finish;
   end

endmodule
